// ===== rtl/core/dtcl_pkg.sv =====
// Shared types, constants and helpers for the directory table block.
`default_nettype none

package dtcl_pkg;

  // Fixed field widths of the command and response.
  localparam int NAME_BYTES     = 15;
  localparam int NAME_RAW_W     = NAME_BYTES * 8;
  localparam int NAME_LOW_W     = 64;
  localparam int NAME_HIGH_W    = 56;
  localparam int NODE_W         = 5;
  localparam int TYPE_W         = 8;
  // Index fields are sized for the largest table.
  localparam int IDX_W          = 8;

  localparam logic [TYPE_W-1:0] DIR_CODE  = 8'd2;
  localparam logic [7:0]        ROOT_CHAR = 8'h2F;

  localparam int DEF_TABLE_ENTRIES = 32;
  localparam int DEF_NAME_CHARS    = 15;

  typedef enum logic {
    MODE_CREATE = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Command fields held for the whole scan and write.
  typedef struct packed {
    mode_e             mode;
    logic [NODE_W-1:0] parent;
    logic [TYPE_W-1:0] etype;
    logic              long_name;
  } cmd_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              node_found;
    logic [IDX_W-1:0]  node_idx;
    logic              entry_found;
    logic [IDX_W-1:0]  entry_idx;
    logic              hit;
    logic [NODE_W-1:0] hit_node;
  } tok_t;

  // Write strobes broadcast to all cells.
  typedef struct packed {
    logic             node_en;
    logic             entry_en;
    logic [IDX_W-1:0] node_idx;
    logic [IDX_W-1:0] entry_idx;
  } wr_t;

  // Clear every byte from the first zero byte on.
  function automatic logic [NAME_RAW_W-1:0] norm_name(input logic [NAME_RAW_W-1:0] raw);
    logic                  live;
    logic [NAME_RAW_W-1:0] res;
    live = 1'b1;
    res  = '0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      live = live && (raw[b*8 +: 8] != 8'h00);
      if (live) begin
        res[b*8 +: 8] = raw[b*8 +: 8];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dtcl_cmd_if.sv =====
// Command channel: valid/ready handshake with create or lookup payload.
`default_nettype none

interface dtcl_cmd_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [dtcl_pkg::NAME_LOW_W-1:0]  name_low;
  logic [dtcl_pkg::NAME_HIGH_W-1:0] name_high;
  logic [dtcl_pkg::NODE_W-1:0]      parent;
  logic [dtcl_pkg::TYPE_W-1:0]      entry_type;

  modport source (output valid, mode, name_low, name_high, parent, entry_type,
                  input ready);
  modport sink   (input valid, mode, name_low, name_high, parent, entry_type,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dtcl_rsp_if.sv =====
// Response channel: valid/ready handshake with status and node number.
`default_nettype none

interface dtcl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [dtcl_pkg::NODE_W-1:0] node_index;

  modport source (output valid, ok, node_index, input ready);
  modport sink   (input valid, ok, node_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/directory_table_create_lookup.sv =====
// Top level: directory table with create and lookup over a chain of slot cells.
//
//   channel  | dir | payload                                          | role
//   ---------+-----+--------------------------------------------------+----------------
//   cmd_i    | in  | mode, name_low, name_high, parent, entry_type    | create / lookup
//   rsp_o    | out | ok, node_index                                   | one per command
//
// A search token enters cell 0 the cycle after a command is accepted and moves one
// cell per cycle down the chain. A new command is taken only after the response
// to the last one has been loaded, so the chain length sets the time per command.
// A create writes its node and entry in the cycle the response is loaded.
// The next command is accepted the cycle after that, even while the response waits.
// A stalled response holds the finished result until the output register frees up.
// Reset restores the root entry at once; no clearing pass is needed.
`default_nettype none

module directory_table_create_lookup #(
  parameter int TABLE_ENTRIES = dtcl_pkg::DEF_TABLE_ENTRIES,
  parameter int NAME_CHARS    = dtcl_pkg::DEF_NAME_CHARS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dtcl_cmd_if.sink   cmd_i,
  dtcl_rsp_if.source rsp_o
);

  localparam int NAME_BITS = NAME_CHARS * 8;
  localparam logic [dtcl_pkg::NAME_RAW_W-1:0] NAME_MASK =
    {dtcl_pkg::NAME_RAW_W{1'b1}} >> (dtcl_pkg::NAME_RAW_W - NAME_BITS);

  dtcl_pkg::state_e            state_q, state_d;
  dtcl_pkg::cmd_t              cmd_q;
  logic [NAME_BITS-1:0]        name_q;
  logic                        start_q;
  dtcl_pkg::tok_t              tok [TABLE_ENTRIES+1];
  dtcl_pkg::tok_t              tok_start;
  dtcl_pkg::tok_t              tok_hold_q;
  dtcl_pkg::wr_t               wr;
  logic [dtcl_pkg::NAME_RAW_W-1:0] name_norm;
  logic                        accept;
  logic                        out_free;
  logic                        load_out;
  logic                        res_ok;
  logic [dtcl_pkg::NODE_W-1:0] res_node;
  logic                        rsp_valid_q;
  logic                        rsp_ok_q;
  logic [dtcl_pkg::NODE_W-1:0] rsp_node_q;

  assign name_norm = dtcl_pkg::norm_name({cmd_i.name_high, cmd_i.name_low});
  assign accept    = cmd_i.valid && cmd_i.ready;
  assign out_free  = !rsp_valid_q || rsp_o.ready;

  // Latch the command with its name cut at the first zero byte.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.mode      <= dtcl_pkg::mode_e'(cmd_i.mode);
      cmd_q.parent    <= cmd_i.parent;
      cmd_q.etype     <= cmd_i.entry_type;
      cmd_q.long_name <= |(name_norm & ~NAME_MASK);
      name_q          <= name_norm[NAME_BITS-1:0];
    end
  end

  // Inject the search token in the cycle after acceptance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= accept;
    end
  end

  always_comb begin
    tok_start       = '0;
    tok_start.valid = start_q;
  end

  assign tok[0] = tok_start;

  // Chain of slot cells.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    dtcl_cell #(
      .CELL_IDX  (g),
      .NAME_CHARS(NAME_CHARS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cmd_i (cmd_q),
      .name_i(name_q),
      .wr_i  (wr),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  // Hold the token that left the last cell.
  always_ff @(posedge clk_i) begin
    if ((state_q == dtcl_pkg::ST_SCAN) && tok[TABLE_ENTRIES].valid) begin
      tok_hold_q <= tok[TABLE_ENTRIES];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtcl_pkg::ST_IDLE: begin
        if (accept) state_d = dtcl_pkg::ST_SCAN;
      end
      dtcl_pkg::ST_SCAN: begin
        if (tok[TABLE_ENTRIES].valid) state_d = dtcl_pkg::ST_DONE;
      end
      dtcl_pkg::ST_DONE: begin
        if (out_free) state_d = dtcl_pkg::ST_IDLE;
      end
      default: state_d = dtcl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtcl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Outputs of the sequencer: ready, response load and write strobes.
  always_comb begin
    cmd_i.ready = (state_q == dtcl_pkg::ST_IDLE);
    load_out    = (state_q == dtcl_pkg::ST_DONE) && out_free;
    if (cmd_q.mode == dtcl_pkg::MODE_CREATE) begin
      res_ok   = tok_hold_q.node_found && tok_hold_q.entry_found;
      res_node = tok_hold_q.node_idx[dtcl_pkg::NODE_W-1:0];
    end else begin
      res_ok   = tok_hold_q.hit;
      res_node = tok_hold_q.hit_node;
    end
    if (!res_ok) begin
      res_node = '0;
    end
    wr.node_en   = load_out && (cmd_q.mode == dtcl_pkg::MODE_CREATE) && res_ok;
    wr.entry_en  = wr.node_en;
    wr.node_idx  = tok_hold_q.node_idx;
    wr.entry_idx = tok_hold_q.entry_idx;
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (load_out) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      rsp_ok_q   <= res_ok;
      rsp_node_q <= res_node;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.ok         = rsp_ok_q;
  assign rsp_o.node_index = rsp_node_q;

  // Table writes come only from a create.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.entry_en |-> (cmd_q.mode == dtcl_pkg::MODE_CREATE))
    else $error("table write outside a create");

  // The token leaves the chain only while a scan is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[TABLE_ENTRIES].valid |-> (state_q == dtcl_pkg::ST_SCAN))
    else $error("search token out of sequence");

  // A new response follows a finished scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == dtcl_pkg::ST_DONE))
    else $error("response without finished scan");

  // No command is taken while a scan is under way.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dtcl_pkg::ST_SCAN) |-> !cmd_i.ready)
    else $error("command accepted during scan");

endmodule

`default_nettype wire

// ===== rtl/core/dtcl_cell.sv =====
// One table slot: node type plus one directory entry, and its stage of the search chain.
`default_nettype none

module dtcl_cell #(
  parameter int CELL_IDX   = 0,
  parameter int NAME_CHARS = dtcl_pkg::DEF_NAME_CHARS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire dtcl_pkg::cmd_t          cmd_i,
  input  wire logic [NAME_CHARS*8-1:0] name_i,
  input  wire dtcl_pkg::wr_t           wr_i,
  input  wire dtcl_pkg::tok_t          tok_i,
  output dtcl_pkg::tok_t               tok_o
);

  localparam int NAME_BITS = NAME_CHARS * 8;
  localparam logic [dtcl_pkg::IDX_W-1:0] MY_IDX = dtcl_pkg::IDX_W'(CELL_IDX);
  localparam logic                       IS_ROOT = (CELL_IDX == 0);

  logic [dtcl_pkg::TYPE_W-1:0] type_q;
  logic                        used_q;
  logic [NAME_BITS-1:0]        name_q;
  logic [dtcl_pkg::NODE_W-1:0] parent_q;
  logic [dtcl_pkg::NODE_W-1:0] node_q;
  dtcl_pkg::tok_t              tok_d, tok_q;
  logic                        match;

  // Entry matches a lookup when used, same parent and same full name.
  assign match = used_q && (parent_q == cmd_i.parent) && (name_q == name_i)
                 && !cmd_i.long_name;

  // Claim the token for the first free node, first free entry and first hit.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid) begin
      if (!tok_i.node_found && (type_q == '0)) begin
        tok_d.node_found = 1'b1;
        tok_d.node_idx   = MY_IDX;
      end
      if (!tok_i.entry_found && !used_q) begin
        tok_d.entry_found = 1'b1;
        tok_d.entry_idx   = MY_IDX;
      end
      if (!tok_i.hit && match) begin
        tok_d.hit      = 1'b1;
        tok_d.hit_node = node_q;
      end
    end
  end

  // Advance the token one cell per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  // Node type slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q <= IS_ROOT ? dtcl_pkg::DIR_CODE : '0;
    end else if (wr_i.node_en && (wr_i.node_idx == MY_IDX)) begin
      type_q <= cmd_i.etype;
    end
  end

  // Directory entry slot; the root entry exists after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= IS_ROOT;
      name_q   <= IS_ROOT ? NAME_BITS'(dtcl_pkg::ROOT_CHAR) : '0;
      parent_q <= '0;
      node_q   <= '0;
    end else if (wr_i.entry_en && (wr_i.entry_idx == MY_IDX)) begin
      used_q   <= 1'b1;
      name_q   <= name_i;
      parent_q <= cmd_i.parent;
      node_q   <= wr_i.node_idx[dtcl_pkg::NODE_W-1:0];
    end
  end

endmodule

`default_nettype wire
